[hw/rtl/fvpm_pkg.sv]
package fvpm_pkg;

    // Field widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int RECIP_W      = 24;
    localparam int THRESH_W     = 15;
    localparam int CFG_DATA_W   = RECIP_W;
    localparam int CFG_INDEX_W  = 1;
    localparam int CH_W         = 8;

    // Front datapath widths
    localparam int MAG_CMP_W = (SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W;
    localparam int PROD_W    = SAMPLE_WIDTH + RECIP_W;
    localparam int NORMQ_W   = PROD_W - SAMPLE_WIDTH;
    localparam int NORM_W    = 16;

    // Q1.15 unity and the smallest magnitude strictly above each breakpoint
    localparam logic [NORM_W-1:0] ONE_Q15 = 16'd32768;
    localparam logic [NORM_W-1:0] TH_005  = 16'd164;
    localparam logic [NORM_W-1:0] TH_010  = 16'd3277;
    localparam logic [NORM_W-1:0] TH_030  = 16'd9831;
    localparam logic [NORM_W-1:0] TH_060  = 16'd19661;
    localparam logic [NORM_W-1:0] TH_085  = 16'd27853;

    // Register reset values
    localparam logic [RECIP_W-1:0]  RECIP_RESET  = 24'd65536;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd328;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RANGE_RECIPROCAL       = 1'b0,
        REG_SIGNIFICANCE_THRESHOLD = 1'b1
    } cfg_index_t;

    // Color segments
    typedef enum logic [3:0] {
        SEG_NEAR_ZERO = 4'd0,
        SEG_NEUTRAL   = 4'd1,
        SEG_NEG_LOW   = 4'd2,
        SEG_NEG_MID   = 4'd3,
        SEG_NEG_HIGH  = 4'd4,
        SEG_NEG_PEAK  = 4'd5,
        SEG_POS_LOW   = 4'd6,
        SEG_POS_MID   = 4'd7,
        SEG_POS_HIGH  = 4'd8,
        SEG_POS_PEAK  = 4'd9
    } seg_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic [NORM_W-1:0] norm;
        seg_t              seg;
        logic              significant;
    } class_item_t;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Items the block can hold: two front stages, the queue, three back stages
    // and the output register
    localparam int FVPM_CAPACITY = 2 + Q_DEPTH + 4;
    localparam int CAP_W         = $clog2(FVPM_CAPACITY + 1);

    // Back datapath widths
    localparam int CH_COUNT    = 3;
    localparam int CH_RED      = 0;
    localparam int CH_GREEN    = 1;
    localparam int CH_BLUE     = 2;
    localparam int SCALED_W    = 25;   // 1000 * norm
    localparam int KNOT_W      = 11;   // breakpoint in thousandths
    localparam int KNOT_SHIFT  = 15;   // thousandths times 2^15
    localparam int NUM_W       = KNOT_W + KNOT_SHIFT;
    localparam int GAIN_W      = 9;
    localparam int MUL1_W      = GAIN_W + NUM_W;
    localparam int QUO_W       = MUL1_W - KNOT_SHIFT;
    localparam int DIVM_W      = 30;
    localparam int DIV_SHIFT   = 32;
    localparam int MUL2_W      = QUO_W + DIVM_W;
    localparam int NORM_SCALE  = 1000;

    // Reciprocals ceil(2^32 / d); exact floor division for quotients below 2^20
    localparam longint unsigned DIV_ONE = 64'd1 << DIV_SHIFT;
    localparam logic [DIVM_W-1:0] DIVM_5    = DIVM_W'((DIV_ONE + 64'd4) / 64'd5);
    localparam logic [DIVM_W-1:0] DIVM_100  = DIVM_W'((DIV_ONE + 64'd99) / 64'd100);
    localparam logic [DIVM_W-1:0] DIVM_150  = DIVM_W'((DIV_ONE + 64'd149) / 64'd150);
    localparam logic [DIVM_W-1:0] DIVM_200  = DIVM_W'((DIV_ONE + 64'd199) / 64'd200);
    localparam logic [DIVM_W-1:0] DIVM_250  = DIVM_W'((DIV_ONE + 64'd249) / 64'd250);
    localparam logic [DIVM_W-1:0] DIVM_300  = DIVM_W'((DIV_ONE + 64'd299) / 64'd300);
    localparam logic [DIVM_W-1:0] DIVM_1500 = DIVM_W'((DIV_ONE + 64'd1499) / 64'd1500);

    // One channel ramp: base + floor(gain * num / (div * 2^15)),
    // num = 1000 * norm - knot * 2^15 (rising) or knot * 2^15 - 1000 * norm
    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic              falling;
        logic [KNOT_W-1:0] knot;
        logic [DIVM_W-1:0] divm;
        logic [CH_W-1:0]   base;
    } ramp_t;

    typedef ramp_t [CH_COUNT-1:0] ramp_set_t;

    function automatic ramp_t ramp(input int unsigned gain, input logic falling,
                                   input int unsigned knot, input logic [DIVM_W-1:0] divm,
                                   input int unsigned base);
        ramp_t r;
        r.gain    = GAIN_W'(gain);
        r.falling = falling;
        r.knot    = KNOT_W'(knot);
        r.divm    = divm;
        r.base    = CH_W'(base);
        return r;
    endfunction

    function automatic ramp_t flat(input int unsigned base);
        ramp_t r;
        r = ramp(0, 1'b0, 0, DIVM_5, base);
        return r;
    endfunction

    // Ramp table per segment and channel
    function automatic ramp_set_t seg_ramps(input seg_t seg);
        ramp_set_t rs;
        rs = '0;
        case (seg)
            SEG_NEAR_ZERO:
            begin
                rs[CH_RED]   = flat(0);
                rs[CH_GREEN] = ramp(32, 1'b0, 0, DIVM_5, 32);
                rs[CH_BLUE]  = ramp(32, 1'b0, 0, DIVM_5, 48);
            end
            SEG_NEUTRAL:
            begin
                rs[CH_RED]   = ramp(48, 1'b0, 0, DIVM_100, 48);
                rs[CH_GREEN] = ramp(48, 1'b0, 0, DIVM_100, 64);
                rs[CH_BLUE]  = ramp(48, 1'b0, 0, DIVM_100, 48);
            end
            SEG_NEG_LOW:
            begin
                rs[CH_RED]   = flat(0);
                rs[CH_GREEN] = ramp(64, 1'b0, 100, DIVM_200, 64);
                rs[CH_BLUE]  = ramp(32, 1'b0, 100, DIVM_200, 96);
            end
            SEG_NEG_MID:
            begin
                rs[CH_RED]   = flat(0);
                rs[CH_GREEN] = ramp(128, 1'b1, 600, DIVM_300, 0);
                rs[CH_BLUE]  = ramp(127, 1'b0, 300, DIVM_300, 128);
            end
            SEG_NEG_HIGH:
            begin
                rs[CH_RED]   = ramp(8, 1'b0, 600, DIVM_250, 0);
                rs[CH_GREEN] = ramp(8, 1'b0, 600, DIVM_250, 0);
                rs[CH_BLUE]  = ramp(75, 1'b0, 600, DIVM_250, 180);
            end
            SEG_NEG_PEAK:
            begin
                rs[CH_RED]   = ramp(96, 1'b0, 850, DIVM_150, 32);
                rs[CH_GREEN] = ramp(16, 1'b0, 850, DIVM_150, 0);
                rs[CH_BLUE]  = flat(255);
            end
            SEG_POS_LOW:
            begin
                rs[CH_RED]   = ramp(96, 1'b0, 100, DIVM_200, 64);
                rs[CH_GREEN] = ramp(64, 1'b0, 100, DIVM_200, 128);
                rs[CH_BLUE]  = ramp(32, 1'b1, 300, DIVM_200, 0);
            end
            SEG_POS_MID:
            begin
                // green is 192 * (1 - 0.4 t), folded into one falling ramp
                rs[CH_RED]   = ramp(95, 1'b0, 300, DIVM_300, 160);
                rs[CH_GREEN] = ramp(384, 1'b1, 1050, DIVM_1500, 0);
                rs[CH_BLUE]  = flat(0);
            end
            SEG_POS_HIGH:
            begin
                rs[CH_RED]   = flat(255);
                rs[CH_GREEN] = ramp(128, 1'b1, 850, DIVM_250, 0);
                rs[CH_BLUE]  = ramp(32, 1'b0, 600, DIVM_250, 0);
            end
            SEG_POS_PEAK:
            begin
                rs[CH_RED]   = flat(255);
                rs[CH_GREEN] = ramp(64, 1'b0, 850, DIVM_150, 0);
                rs[CH_BLUE]  = ramp(64, 1'b0, 850, DIVM_150, 0);
            end
            default:
            begin
                rs = '0;
            end
        endcase
        return rs;
    endfunction

endpackage

[hw/rtl/fvpm_in_if.sv]
interface fvpm_in_if
    import fvpm_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] field_sample;

    modport source (output valid, output field_sample, input ready);
    modport sink   (input valid, input field_sample, output ready);
endinterface

[hw/rtl/fvpm_out_if.sv]
interface fvpm_out_if
    import fvpm_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            significant;

    modport source (output valid, output red, output green, output blue,
                    output significant, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input significant, output ready);
endinterface

[hw/rtl/fvpm_front.sv]
module fvpm_front
    import fvpm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    fvpm_in_if.sink                samples,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  queue_status_t          q_status,
    output logic                   item_valid,
    output class_item_t            item
);

    logic [RECIP_W-1:0]      recip_reg;
    logic [THRESH_W-1:0]     thresh_reg;

    logic                    f1_valid_reg;
    logic [SAMPLE_WIDTH-1:0] f1_mag_reg;
    logic                    f1_neg_reg;
    logic                    f1_sig_reg;

    logic                    f2_valid_reg;
    logic [PROD_W-1:0]       f2_prod_reg;
    logic                    f2_neg_reg;
    logic                    f2_sig_reg;

    logic                    advance;
    logic [SAMPLE_WIDTH-1:0] raw_bits;
    logic                    raw_neg;
    logic [SAMPLE_WIDTH-1:0] raw_mag;
    logic                    raw_sig;
    logic [NORMQ_W-1:0]      norm_full;
    logic [NORM_W-1:0]       norm;
    seg_t                    seg;

    // Whole front moves unless its last item waits on a full queue
    assign advance       = !f2_valid_reg || !q_status.full;
    assign samples.ready = advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recip_reg  <= RECIP_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index_t'(cfg_index))
                REG_RANGE_RECIPROCAL:       recip_reg  <= cfg_wdata[RECIP_W-1:0];
                REG_SIGNIFICANCE_THRESHOLD: thresh_reg <= cfg_wdata[THRESH_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Sign and magnitude; the most negative sample gives 2^(W-1)
    always_comb
    begin
        raw_bits = samples.field_sample;
        raw_neg  = raw_bits[SAMPLE_WIDTH-1];
        raw_mag  = raw_neg ? (SAMPLE_WIDTH'(~raw_bits) + SAMPLE_WIDTH'(1)) : raw_bits;
        raw_sig  = MAG_CMP_W'(raw_mag) > MAG_CMP_W'(thresh_reg);
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            f1_valid_reg <= samples.valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    // Stage payloads: magnitude, then scaled magnitude
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f1_mag_reg  <= raw_mag;
            f1_neg_reg  <= raw_neg;
            f1_sig_reg  <= raw_sig;
            f2_prod_reg <= PROD_W'(f1_mag_reg) * PROD_W'(recip_reg);
            f2_neg_reg  <= f1_neg_reg;
            f2_sig_reg  <= f1_sig_reg;
        end
    end

    // Q1.15 normalize with saturation at 1.0
    always_comb
    begin
        norm_full = f2_prod_reg[PROD_W-1:SAMPLE_WIDTH];
        if (norm_full > NORMQ_W'(ONE_Q15))
            norm = ONE_Q15;
        else
            norm = norm_full[NORM_W-1:0];
    end

    // Segment select
    always_comb
    begin
        if (norm < TH_005)
            seg = SEG_NEAR_ZERO;
        else if (f2_neg_reg)
        begin
            if (norm >= TH_085)
                seg = SEG_NEG_PEAK;
            else if (norm >= TH_060)
                seg = SEG_NEG_HIGH;
            else if (norm >= TH_030)
                seg = SEG_NEG_MID;
            else if (norm >= TH_010)
                seg = SEG_NEG_LOW;
            else
                seg = SEG_NEUTRAL;
        end
        else
        begin
            if (norm < TH_010)
                seg = SEG_NEUTRAL;
            else if (norm < TH_030)
                seg = SEG_POS_LOW;
            else if (norm < TH_060)
                seg = SEG_POS_MID;
            else if (norm < TH_085)
                seg = SEG_POS_HIGH;
            else
                seg = SEG_POS_PEAK;
        end
    end

    assign item_valid       = f2_valid_reg;
    assign item.norm        = norm;
    assign item.seg         = seg;
    assign item.significant = f2_sig_reg;

endmodule

[hw/rtl/fvpm_queue.sv]
module fvpm_queue
    import fvpm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  class_item_t   push_item,
    input  logic          pop_en,
    output class_item_t   pop_item,
    output queue_status_t status
);

    class_item_t        entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               push;
    logic               pop;

    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign push         = push_valid && !status.full;
    assign pop          = pop_en && !status.empty;
    assign pop_item     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + Q_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - Q_CNT_W'(1);
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[hw/rtl/fvpm_back.sv]
module fvpm_back
    import fvpm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  class_item_t   pop_item,
    output logic          pop_en,
    fvpm_out_if.source    colors
);

    logic                       b_en;

    logic                       b1_valid_reg;
    logic                       b2_valid_reg;
    logic                       b3_valid_reg;
    logic                       out_valid_reg;

    seg_t                       b1_seg_reg;
    seg_t                       b2_seg_reg;
    seg_t                       b3_seg_reg;
    logic                       b1_sig_reg;
    logic                       b2_sig_reg;
    logic                       b3_sig_reg;
    logic                       out_sig_reg;

    logic [CH_COUNT-1:0][NUM_W-1:0] b1_num_reg;
    logic [CH_COUNT-1:0][QUO_W-1:0] b2_quo_reg;
    logic [CH_COUNT-1:0][CH_W-1:0]  b3_ramp_reg;
    logic [CH_COUNT-1:0][CH_W-1:0]  out_rgb_reg;

    ramp_set_t                  q_rs;
    ramp_set_t                  b1_rs;
    ramp_set_t                  b2_rs;
    ramp_set_t                  b3_rs;
    logic [SCALED_W-1:0]        scaled;

    // Back pipeline holds as a whole while a result waits at the output
    assign b_en   = !out_valid_reg || colors.ready;
    assign pop_en = b_en;

    assign q_rs   = seg_ramps(pop_item.seg);
    assign b1_rs  = seg_ramps(b1_seg_reg);
    assign b2_rs  = seg_ramps(b2_seg_reg);
    assign b3_rs  = seg_ramps(b3_seg_reg);
    assign scaled = SCALED_W'(32'(pop_item.norm) * 32'(NORM_SCALE));

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (b_en)
        begin
            b1_valid_reg  <= !q_status.empty;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            out_valid_reg <= b3_valid_reg;
        end
    end

    // Segment and flag travel with the item
    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            b1_seg_reg  <= pop_item.seg;
            b2_seg_reg  <= b1_seg_reg;
            b3_seg_reg  <= b2_seg_reg;
            b1_sig_reg  <= pop_item.significant;
            b2_sig_reg  <= b1_sig_reg;
            b3_sig_reg  <= b2_sig_reg;
            out_sig_reg <= b3_sig_reg;
        end
    end

    // One ramp lane per color channel
    for (genvar c = 0; c < CH_COUNT; c++)
    begin : g_lane
        logic [NUM_W-1:0]  knot_full;
        logic [NUM_W-1:0]  num;
        logic [MUL1_W-1:0] prod1;
        logic [MUL2_W-1:0] prod2;

        // distance from the segment knot, in thousandths times 2^15
        always_comb
        begin
            knot_full = NUM_W'(q_rs[c].knot) << KNOT_SHIFT;
            if (q_rs[c].falling)
                num = knot_full - NUM_W'(scaled);
            else
                num = NUM_W'(scaled) - knot_full;
        end

        assign prod1 = MUL1_W'(b1_rs[c].gain) * MUL1_W'(b1_num_reg[c]);
        assign prod2 = MUL2_W'(b2_quo_reg[c]) * MUL2_W'(b2_rs[c].divm);

        always_ff @(posedge clk)
        begin
            if (b_en)
            begin
                b1_num_reg[c]  <= num;
                b2_quo_reg[c]  <= prod1[MUL1_W-1:KNOT_SHIFT];
                b3_ramp_reg[c] <= prod2[DIV_SHIFT+CH_W-1:DIV_SHIFT];
                out_rgb_reg[c] <= b3_ramp_reg[c] + b3_rs[c].base;
            end
        end
    end

    assign colors.valid       = out_valid_reg;
    assign colors.red         = out_rgb_reg[CH_RED];
    assign colors.green       = out_rgb_reg[CH_GREEN];
    assign colors.blue        = out_rgb_reg[CH_BLUE];
    assign colors.significant = out_sig_reg;

endmodule

[hw/rtl/field_value_pseudocolor_map_core.sv]
// A result is valid once its sample has passed the 2 front stages, a queue write,
// 3 ramp stages and the output register.
// Throughput: one item per cycle; the front keeps accepting into a 4-entry queue
// while a result waits at the output, and stalls only when that queue is full.
// Reset (rst_n, asynchronous, active low) empties all stages and the queue and
// loads range_reciprocal = 65536 and significance_threshold = 328.
module field_value_pseudocolor_map_core
    import fvpm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    fvpm_in_if.sink                samples,
    fvpm_out_if.source             colors,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    queue_status_t q_status;
    logic          item_valid;
    class_item_t   item;
    logic          pop_en;
    class_item_t   pop_item;

    // Front: magnitude, scaling, segment select
    fvpm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .q_status   (q_status),
        .item_valid (item_valid),
        .item       (item)
    );

    // Decoupling queue
    fvpm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (item_valid),
        .push_item  (item),
        .pop_en     (pop_en),
        .pop_item   (pop_item),
        .status     (q_status)
    );

    // Back: per-channel ramps
    fvpm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_item (pop_item),
        .pop_en   (pop_en),
        .colors   (colors)
    );

endmodule

[hw/rtl/fvpm_checker.sv]
module fvpm_checker
    import fvpm_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic [CH_W-1:0] red,
    input logic [CH_W-1:0] green,
    input logic [CH_W-1:0] blue,
    input logic            significant
);

    logic [CAP_W-1:0] outstanding_reg;
    logic [CAP_W-1:0] outstanding_next;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Items accepted but not yet delivered
    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (in_acc && !out_acc)
            outstanding_next = outstanding_reg + CAP_W'(1);
        else if (out_acc && !in_acc)
            outstanding_next = outstanding_reg - CAP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= '0;
        else
            outstanding_reg <= outstanding_next;
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({red, green, blue, significant}))
        else $error("result changed while stalled");

    // No result without an accepted item behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> outstanding_reg != '0)
        else $error("result with no item in flight");

    // Never more in flight than the block can store
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= CAP_W'(FVPM_CAPACITY))
        else $error("more items in flight than storage");

    // Input stalls only once the queue is full and the last front stage holds an item
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> outstanding_reg >= CAP_W'(Q_DEPTH + 1))
        else $error("input stalled with room left");

endmodule

bind field_value_pseudocolor_map_core fvpm_checker u_fvpm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (samples.valid),
    .in_ready    (samples.ready),
    .out_valid   (colors.valid),
    .out_ready   (colors.ready),
    .red         (colors.red),
    .green       (colors.green),
    .blue        (colors.blue),
    .significant (colors.significant)
);
